/* hdl/triangle_barycentric_weights_unit_assert.svh */
// Assertion macros used by the checker file of the barycentric weights unit.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("barycentric weights unit: implication check failed");

// Consequent must hold after the antecedent, delayed by the dly argument.
`define TBW_ASSERT_AFTER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("barycentric weights unit: delayed check failed");

`endif

/* hdl/tbw_pkg.sv */
package tbw_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int CSR_W       = 32;
   localparam logic [CSR_W-1:0] TOL_RESET = 32'd4295;

   // Exact widths of the intermediate values.
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int MUL_W   = 2 * DIFF_W;
   localparam int CROSS_W = MUL_W + 1;
   localparam int NORM_W  = CROSS_W + 2;
   localparam int PROD_W  = CROSS_W + NORM_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int TOT_W   = DOT_W + 2;
   localparam int NUM_W   = TOT_W + FRAC_BITS;
   localparam int HIGH_W  = NUM_W - COORD_WIDTH;
   localparam int CMP_W   = (HIGH_W > TOT_W) ? HIGH_W : TOT_W;

   // Operand split for the wide dot product multipliers.
   localparam int SPLIT_A = CROSS_W / 2;
   localparam int SPLIT_B = NORM_W / 2;

   localparam int CROSS_LAT = 3;
   localparam int DOT_LAT   = 5;
   localparam int DIV_LAT   = COORD_WIDTH + 3;
   localparam int PIPE_LAT  = CROSS_LAT + DOT_LAT + DIV_LAT;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [CROSS_W-1:0]     cross_type;
   typedef logic signed [NORM_W-1:0]      norm_type;
   typedef logic signed [TOT_W-1:0]       wide_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_a_x;
      logic signed [COORD_WIDTH-1:0] vertex_a_y;
      logic signed [COORD_WIDTH-1:0] vertex_a_z;
      logic signed [COORD_WIDTH-1:0] vertex_b_x;
      logic signed [COORD_WIDTH-1:0] vertex_b_y;
      logic signed [COORD_WIDTH-1:0] vertex_b_z;
      logic signed [COORD_WIDTH-1:0] vertex_c_x;
      logic signed [COORD_WIDTH-1:0] vertex_c_y;
      logic signed [COORD_WIDTH-1:0] vertex_c_z;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] weight_a;
      logic signed [COORD_WIDTH-1:0] weight_b;
      logic signed [COORD_WIDTH-1:0] weight_c;
      logic                          used_fallback;
      logic                          degenerate;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic fallback;
      logic degen;
   } tag_type;

endpackage

/* hdl/tbw_cross.sv */
module tbw_cross (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   input  tbw_pkg::req_word_type req_i,
   output logic                 valid_o,
   output tbw_pkg::cross_type   cross_o [9]
);
   import tbw_pkg::*;

   coord_type vtx [4][3];
   diff_type  edge_in [9];
   diff_type  pnt_in  [9];
   diff_type  edge_ff [9];
   diff_type  pnt_ff  [9];
   logic signed [MUL_W-1:0] mul_in [18];
   logic signed [MUL_W-1:0] mul_ff [18];
   cross_type cross_in [9];
   cross_type cross_ff [9];
   logic [CROSS_LAT-1:0] vld_ff;

   function automatic diff_type dsub(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   always_comb begin
      vtx[0][0] = req_i.vertex_a_x; vtx[0][1] = req_i.vertex_a_y; vtx[0][2] = req_i.vertex_a_z;
      vtx[1][0] = req_i.vertex_b_x; vtx[1][1] = req_i.vertex_b_y; vtx[1][2] = req_i.vertex_b_z;
      vtx[2][0] = req_i.vertex_c_x; vtx[2][1] = req_i.vertex_c_y; vtx[2][2] = req_i.vertex_c_z;
      vtx[3][0] = req_i.point_x;    vtx[3][1] = req_i.point_y;    vtx[3][2] = req_i.point_z;
   end

   // Edge and point vectors for the three cross products: bc, ca and ab.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         edge_in[k]   = dsub(vtx[2][k], vtx[1][k]);
         pnt_in[k]    = dsub(vtx[3][k], vtx[1][k]);
         edge_in[3+k] = dsub(vtx[0][k], vtx[2][k]);
         pnt_in[3+k]  = dsub(vtx[3][k], vtx[2][k]);
         edge_in[6+k] = dsub(vtx[1][k], vtx[0][k]);
         pnt_in[6+k]  = dsub(vtx[3][k], vtx[0][k]);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mul_in[6*c+0] = edge_ff[3*c+1] * pnt_ff[3*c+2];
         mul_in[6*c+1] = edge_ff[3*c+2] * pnt_ff[3*c+1];
         mul_in[6*c+2] = edge_ff[3*c+2] * pnt_ff[3*c+0];
         mul_in[6*c+3] = edge_ff[3*c+0] * pnt_ff[3*c+2];
         mul_in[6*c+4] = edge_ff[3*c+0] * pnt_ff[3*c+1];
         mul_in[6*c+5] = edge_ff[3*c+1] * pnt_ff[3*c+0];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 3; k++) begin
            cross_in[3*c+k] = CROSS_W'(mul_ff[6*c+2*k]) - CROSS_W'(mul_ff[6*c+2*k+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      edge_ff  <= edge_in;
      pnt_ff   <= pnt_in;
      mul_ff   <= mul_in;
      cross_ff <= cross_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CROSS_LAT-2:0], valid_i};
      end
   end

   assign valid_o = vld_ff[CROSS_LAT-1];
   assign cross_o = cross_ff;

endmodule

/* hdl/tbw_dot.sv */
module tbw_dot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_i,
   input  tbw_pkg::cross_type        cross_i [9],
   input  logic [tbw_pkg::CSR_W-1:0] tol_i,
   output tbw_pkg::tag_type          tag_o,
   output tbw_pkg::wide_type         num_o [3],
   output tbw_pkg::wide_type         den_o
);
   import tbw_pkg::*;

   localparam int AH_W = CROSS_W - SPLIT_A;
   localparam int BH_W = NORM_W - SPLIT_B;

   typedef struct packed {
      logic                      fast;
      logic signed [CROSS_W-1:0] xa;
      logic signed [CROSS_W-1:0] xb;
      logic signed [CROSS_W-1:0] xc;
      logic signed [NORM_W-1:0]  xs;
   } fast_type;

   cross_type cr_ff [9];
   norm_type  n_in  [3];
   norm_type  n_ff  [3];
   logic signed [PROD_W-1:0] pp_in [9][4];
   logic signed [PROD_W-1:0] pp_ff [9][4];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [DOT_W-1:0]  t_in [3];
   logic signed [DOT_W-1:0]  t_ff [3];
   wide_type                 tot_in;
   logic [NORM_W-1:0]        mag_in;
   fast_type                 fp_in;
   fast_type                 fp2_ff, fp3_ff, fp4_ff;
   logic [DOT_LAT-2:0]       vld_ff;
   tag_type                  tag_in, tag_ff;
   wide_type                 num_in [3];
   wide_type                 num_ff [3];
   wide_type                 den_in, den_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_in[k] = NORM_W'(cross_i[k]) + NORM_W'(cross_i[3+k]) + NORM_W'(cross_i[6+k]);
      end
   end

   // Each dot term is cut into four partial products over the operand halves.
   always_comb begin
      logic signed [AH_W-1:0]        a_hi;
      logic signed [SPLIT_A:0]       a_lo;
      logic signed [BH_W-1:0]        b_hi;
      logic signed [SPLIT_B:0]       b_lo;
      logic signed [AH_W+BH_W-1:0]   m_hh;
      logic signed [AH_W+SPLIT_B:0]  m_hl;
      logic signed [SPLIT_A+BH_W:0]  m_lh;
      logic signed [SPLIT_A+SPLIT_B+1:0] m_ll;
      for (int d = 0; d < 9; d++) begin
         a_hi = cr_ff[d][CROSS_W-1:SPLIT_A];
         a_lo = {1'b0, cr_ff[d][SPLIT_A-1:0]};
         b_hi = n_ff[d%3][NORM_W-1:SPLIT_B];
         b_lo = {1'b0, n_ff[d%3][SPLIT_B-1:0]};
         m_hh = a_hi * b_hi;
         m_hl = a_hi * b_lo;
         m_lh = a_lo * b_hi;
         m_ll = a_lo * b_lo;
         pp_in[d][0] = PROD_W'(m_hh);
         pp_in[d][1] = PROD_W'(m_hl);
         pp_in[d][2] = PROD_W'(m_lh);
         pp_in[d][3] = PROD_W'(m_ll);
      end
   end

   always_comb begin
      mag_in = n_ff[0][NORM_W-1] ? NORM_W'(-n_ff[0]) : NORM_W'(n_ff[0]);
      fp_in.fast = mag_in > {{(NORM_W-CSR_W){1'b0}}, tol_i};
      fp_in.xa   = cr_ff[0];
      fp_in.xb   = cr_ff[3];
      fp_in.xc   = cr_ff[6];
      fp_in.xs   = n_ff[0];
   end

   always_comb begin
      for (int d = 0; d < 9; d++) begin
         prod_in[d] = (pp_ff[d][0] <<< (SPLIT_A + SPLIT_B)) + (pp_ff[d][1] <<< SPLIT_A)
                    + (pp_ff[d][2] <<< SPLIT_B) + pp_ff[d][3];
      end
      for (int i = 0; i < 3; i++) begin
         t_in[i] = DOT_W'(prod_ff[3*i]) + DOT_W'(prod_ff[3*i+1]) + DOT_W'(prod_ff[3*i+2]);
      end
   end

   always_comb begin
      tot_in = TOT_W'(t_ff[0]) + TOT_W'(t_ff[1]) + TOT_W'(t_ff[2]);
      if (fp4_ff.fast) begin
         num_in[0] = TOT_W'(fp4_ff.xa);
         num_in[1] = TOT_W'(fp4_ff.xb);
         num_in[2] = TOT_W'(fp4_ff.xc);
         den_in    = TOT_W'(fp4_ff.xs);
      end else begin
         num_in[0] = TOT_W'(t_ff[0]);
         num_in[1] = TOT_W'(t_ff[1]);
         num_in[2] = TOT_W'(t_ff[2]);
         den_in    = tot_in;
      end
      tag_in.valid    = vld_ff[DOT_LAT-2];
      tag_in.fallback = !fp4_ff.fast;
      tag_in.degen    = !fp4_ff.fast && (tot_in == '0);
   end

   always_ff @(posedge clock) begin
      cr_ff   <= cross_i;
      n_ff    <= n_in;
      pp_ff   <= pp_in;
      fp2_ff  <= fp_in;
      prod_ff <= prod_in;
      fp3_ff  <= fp2_ff;
      t_ff    <= t_in;
      fp4_ff  <= fp3_ff;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tag_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DOT_LAT-3:0], valid_i};
         tag_ff <= tag_in;
      end
   end

   assign tag_o = tag_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;

endmodule

/* hdl/tbw_div.sv */
module tbw_div (
   input  logic               clock,
   input  tbw_pkg::wide_type  num_i,
   input  tbw_pkg::wide_type  den_i,
   output tbw_pkg::coord_type quo_o
);
   import tbw_pkg::*;

   localparam int C = COORD_WIDTH;
   localparam logic [C-1:0] LIMIT_POS = {1'b0, {(C-1){1'b1}}};
   localparam logic [C-1:0] LIMIT_NEG = {1'b1, {(C-1){1'b0}}};

   logic [TOT_W-1:0] mn_ff, md1_ff;
   logic             neg1_ff, dz1_ff;
   logic [NUM_W-1:0] mnf;

   logic [TOT_W-1:0] rem_ff [C+1];
   logic [C-1:0]     q_ff   [C+1];
   logic [C-1:0]     lo_ff  [C+1];
   logic [TOT_W-1:0] md_ff  [C+1];
   logic [C:0]       neg_ff, ovf_ff, dz_ff;

   logic [C-1:0]     lim, qv;
   coord_type        quo_in, quo_ff;

   always_ff @(posedge clock) begin
      neg1_ff <= num_i[TOT_W-1] ^ den_i[TOT_W-1];
      dz1_ff  <= (den_i == '0);
      mn_ff   <= num_i[TOT_W-1] ? TOT_W'(-num_i) : TOT_W'(num_i);
      md1_ff  <= den_i[TOT_W-1] ? TOT_W'(-den_i) : TOT_W'(den_i);
   end

   // The quotient has to fit in C bits; anything at or above 2^C saturates.
   assign mnf = {mn_ff, {FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      ovf_ff[0] <= CMP_W'(mnf[NUM_W-1:C]) >= CMP_W'(md1_ff);
      rem_ff[0] <= TOT_W'(mnf[NUM_W-1:C]);
      lo_ff[0]  <= mnf[C-1:0];
      q_ff[0]   <= '0;
      md_ff[0]  <= md1_ff;
      neg_ff[0] <= neg1_ff;
      dz_ff[0]  <= dz1_ff;
   end

   for (genvar k = 1; k <= C; k++) begin : g_step
      logic [TOT_W:0] rem2;
      logic           ge;
      assign rem2 = {rem_ff[k-1], lo_ff[k-1][C-1]};
      assign ge   = rem2 >= {1'b0, md_ff[k-1]};
      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? TOT_W'(rem2 - {1'b0, md_ff[k-1]}) : TOT_W'(rem2);
         q_ff[k]   <= {q_ff[k-1][C-2:0], ge};
         lo_ff[k]  <= {lo_ff[k-1][C-2:0], 1'b0};
         md_ff[k]  <= md_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         dz_ff[k]  <= dz_ff[k-1];
      end
   end

   always_comb begin
      lim = neg_ff[C] ? LIMIT_NEG : LIMIT_POS;
      qv  = (ovf_ff[C] || (q_ff[C] > lim)) ? lim : q_ff[C];
      if (dz_ff[C]) begin
         quo_in = '0;
      end else if (neg_ff[C]) begin
         quo_in = coord_type'(-qv);
      end else begin
         quo_in = coord_type'(qv);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo_o = quo_ff;

endmodule

/* hdl/triangle_barycentric_weights_unit.sv */
// Channel   Ports                          Direction  Handshake
// request   start, busy, req_word          in         taken when start and not busy
// response  rsp_valid, rsp_word            out        one cycle per word, no back-pressure
// csr       csr_we, csr_wdata              in         area tolerance, written when csr_we
//
// A word is taken in every cycle in which start is high; busy is always low.
// Each response passes the cross products, then the normal and dot products, and then
// the divider, which resolves one quotient bit a stage.
// Reset clears the valid bits and sets the area tolerance to 4295.
// The receiver cannot stall, so the pipeline never holds.
module triangle_barycentric_weights_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tbw_pkg::req_word_type     req_word,
   output logic                      rsp_valid,
   output tbw_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_we,
   input  logic [tbw_pkg::CSR_W-1:0] csr_wdata
);
   import tbw_pkg::*;

   logic [CSR_W-1:0] tol_ff;
   logic             accept;
   logic             cross_vld;
   cross_type        cross_w [9];
   tag_type          dot_tag;
   wide_type         num_w [3];
   wide_type         den_w;
   coord_type        quo_w [3];
   tag_type          tag_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   assign busy   = 1'b0;
   assign accept = start && !busy;

   tbw_cross u_cross (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .req_i   (req_word),
      .valid_o (cross_vld),
      .cross_o (cross_w)
   );

   tbw_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .valid_i (cross_vld),
      .cross_i (cross_w),
      .tol_i   (tol_ff),
      .tag_o   (dot_tag),
      .num_o   (num_w),
      .den_o   (den_w)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      tbw_div u_div (
         .clock (clock),
         .num_i (num_w[i]),
         .den_i (den_w),
         .quo_o (quo_w[i])
      );
   end

   // Flags ride alongside the dividers so they meet their quotients at the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[0] <= dot_tag;
         for (int k = 1; k < DIV_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign rsp_valid              = tag_ff[DIV_LAT-1].valid;
   assign rsp_word.weight_a      = quo_w[0];
   assign rsp_word.weight_b      = quo_w[1];
   assign rsp_word.weight_c      = quo_w[2];
   assign rsp_word.used_fallback = tag_ff[DIV_LAT-1].fallback;
   assign rsp_word.degenerate    = tag_ff[DIV_LAT-1].degen;

endmodule

/* hdl/tbw_checker.sv */
`include "triangle_barycentric_weights_unit_assert.svh"

module tbw_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input tbw_pkg::req_word_type     req_word,
   input logic                      rsp_valid,
   input tbw_pkg::rsp_word_type     rsp_word,
   input logic                      csr_we,
   input logic [tbw_pkg::CSR_W-1:0] csr_wdata
);
   import tbw_pkg::*;

   // Every accepted word comes out after the fixed pipeline latency.
   `TBW_ASSERT_AFTER(a_resp_follows, clock, reset, start && !busy, PIPE_LAT, rsp_valid)

   // No response appears without a request that latency earlier.
   `TBW_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, PIPE_LAT))

   // A degenerate triangle is only reported on the fallback path, with zero weights.
   `TBW_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_word.degenerate,
      rsp_word.used_fallback && (rsp_word.weight_a == '0) && (rsp_word.weight_b == '0)
      && (rsp_word.weight_c == '0))

endmodule

bind triangle_barycentric_weights_unit tbw_checker u_tbw_checker (.*);
